// File: sv/lss_pkg.sv
// Shared types and codes for the LIFO stack with membership search.
// Used by lss_cell and by the top level lifo_stack_with_search.
package lss_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CHECK = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;   // every cell takes its upper neighbor's entry
    logic pop;    // every cell takes its lower neighbor's entry
    logic load;   // every cell registers its own compare result
    logic shift;  // compare results move one cell toward the top
  } cell_ctrl_t;

  // One result beat, packed with status in the lowest bits.
  typedef struct packed {
    logic [7:0] count;
    logic       found;
    status_e    status;
  } res_t;

endpackage

// File: sv/lss_cell.sv
// One storage cell of the stack chain: an entry, its occupied flag and a match bit.
// Depends on lss_pkg for the command struct and the word width.
module lss_cell
  import lss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [WordW-1:0] value_i,
  input  logic [WordW-1:0] up_data_i,
  input  logic             up_occ_i,
  input  logic [WordW-1:0] dn_data_i,
  input  logic             dn_occ_i,
  input  logic             dn_match_i,
  output logic [WordW-1:0] data_o,
  output logic             occ_o,
  output logic             match_o
);

  logic [WordW-1:0] data_q;
  logic             occ_q, occ_d;
  logic             match_q, match_d;

  always_comb begin
    occ_d = occ_q;
    if (ctrl_i.push) begin
      occ_d = up_occ_i;
    end else if (ctrl_i.pop) begin
      occ_d = dn_occ_i;
    end
    match_d = match_q;
    if (ctrl_i.load) begin
      match_d = occ_q && (data_q == value_i);
    end else if (ctrl_i.shift) begin
      match_d = dn_match_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= 1'b0;
      match_q <= 1'b0;
    end else begin
      occ_q   <= occ_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      data_q <= up_data_i;
    end else if (ctrl_i.pop) begin
      data_q <= dn_data_i;
    end
  end

  assign data_o  = data_q;
  assign occ_o   = occ_q;
  assign match_o = match_q;

endmodule

// File: sv/lifo_stack_with_search.sv
// Push, pop and unused codes form their result beat in the accepting cycle and register it
// into the output buffer; a check does so when its scan of count (entries held) ends, or at
// once on empty. One push or pop per cycle while the skid register is free; a check holds
// the input while the match bits drain one cell per cycle through the top of the cell chain.
// Reset (rst_ni low, asynchronous) empties the stack and the output buffer; entry
// contents are not cleared, only their occupied flags.
module lifo_stack_with_search
  import lss_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] operation, [33:2] value, [39:34] zero
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [2] found, [10:3] count, [15:11] zero
  output logic [15:0] m_axis_tdata
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // The stack is a chain of cells with the top at cell 0. A push moves every
  // entry one cell down and writes the new value into cell 0; a pop moves every
  // entry one cell up. The occupied flags travel with the entries, so they
  // always form a run of ones from cell 0 whose length is the fill count.

  logic [WordW-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0] cell_occ;
  logic [DEPTH-1:0] cell_match;
  cell_ctrl_t       ctrl;

  logic [1:0]       in_op;
  logic [WordW-1:0] in_value;
  logic             in_fire;

  assign in_op    = s_axis_tdata[1:0];
  assign in_value = s_axis_tdata[33:2];
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WordW-1:0] up_data, dn_data;
    logic             up_occ, dn_occ, dn_match;

    if (i == 0) begin : g_top
      assign up_data = in_value;
      assign up_occ  = 1'b1;
    end else begin : g_mid_up
      assign up_data = cell_data[i-1];
      assign up_occ  = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign dn_data  = cell_data[i];
      assign dn_occ   = 1'b0;
      assign dn_match = 1'b0;
    end else begin : g_mid_dn
      assign dn_data  = cell_data[i+1];
      assign dn_occ   = cell_occ[i+1];
      assign dn_match = cell_match[i+1];
    end

    lss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .value_i    (in_value),
      .up_data_i  (up_data),
      .up_occ_i   (up_occ),
      .dn_data_i  (dn_data),
      .dn_occ_i   (dn_occ),
      .dn_match_i (dn_match),
      .data_o     (cell_data[i]),
      .occ_o      (cell_occ[i]),
      .match_o    (cell_match[i])
    );
  end

  // Control. A check first makes every cell register its own compare result,
  // then the match bits shift toward cell 0 until the bit of every held entry
  // has reached it, and the controller collects them there one at a time.

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_q, scan_d;
  logic          hit_q, hit_d;
  logic          res_valid;
  res_t          res;
  logic          full;

  assign full = (count_q == CW'(DEPTH));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_d     = scan_q;
    hit_d      = hit_q;
    ctrl       = '0;
    res_valid  = 1'b0;
    res.status = ST_DONE;
    res.found  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_valid = 1'b1;
          case (op_e'(in_op))
            OP_PUSH: begin
              if (full) begin
                res.status = ST_FULL;
              end else begin
                ctrl.push = 1'b1;
                count_d   = count_q + 1'b1;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                res.status = ST_EMPTY;
              end else begin
                ctrl.pop = 1'b1;
                count_d  = count_q - 1'b1;
              end
            end
            OP_CHECK: begin
              if (count_q != '0) begin
                res_valid = 1'b0;
                ctrl.load = 1'b1;
                scan_d    = count_q;
                hit_d     = 1'b0;
                state_d   = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        ctrl.shift = 1'b1;
        hit_d      = hit_q | cell_match[0];
        scan_d     = scan_q - 1'b1;
        if (scan_q == CW'(1)) begin
          res_valid = 1'b1;
          res.found = hit_d;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    res.count = 8'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      scan_q  <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      hit_q   <= hit_d;
    end
  end

  // Two-beat output buffer: the output register plus a skid register, so a
  // new item is taken while a finished beat still waits at the output.

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic out_take;

  assign out_take = out_valid_q && m_axis_tready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = res_valid;
        skid_d       = res;
      end else begin
        out_valid_d = res_valid;
        out_d       = res;
      end
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // A new item is taken only while no check is scanning and the buffer has
  // room for its beat.
  assign s_axis_tready = (state_q == S_IDLE) && !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_q};

`ifndef SYNTH
  // The occupied flags always agree with the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_occ) == int'(count_q))
    else $error("occupied cells disagree with the fill count");

  // While a check is scanning no new item may be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> !s_axis_tready)
    else $error("input taken during a scan");

  // A check on a non-empty stack starts a scan and gives no beat at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_op == OP_CHECK && count_q != '0) |=> (state_q == S_SCAN))
    else $error("check did not start a scan");

  // The skid register only fills while the output register is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid beat without an output beat");
`endif

endmodule
